FILE: rtl/mfhv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfhv_pkg
// Shared constants, types and codes for the mesh frame header validator.
// ----------------------------------------------------------------------------
package mfhv_pkg;

  localparam int unsigned MAX_FRAME   = 256;
  localparam int unsigned ID_BYTES    = 6;
  localparam int unsigned HDR_PLAIN   = 10 + ID_BYTES;
  localparam int unsigned HDR_ADDR    = 10 + 2 * ID_BYTES;
  localparam int unsigned LEN_MAX     = MAX_FRAME + 1;
  localparam int unsigned LEN_W       = $clog2(LEN_MAX + 1);
  localparam int unsigned HDR_IDX_W   = $clog2(HDR_ADDR);
  localparam int unsigned ACK_PAYLOAD = 4;
  localparam int unsigned CFG_LEN_W   = 9;
  localparam int unsigned CMP_W       = (LEN_W > CFG_LEN_W + 1) ? LEN_W : CFG_LEN_W + 1;
  localparam int unsigned ID_W        = 48;
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 48;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_VERSION = 3'd3,
    ST_TYPE    = 3'd4,
    ST_FLAGS   = 3'd5,
    ST_LENGTH  = 3'd6,
    ST_HOPS    = 3'd7
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC     = 3'd0,
    CFG_VERSION   = 3'd1,
    CFG_TYPES     = 3'd2,
    CFG_ADDR_MASK = 3'd3,
    CFG_HOP_MAX   = 3'd4,
    CFG_BEACON    = 3'd5,
    CFG_OVERHEAD  = 3'd6,
    CFG_PT_MAX    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_e         status;
    logic [7:0]      packet_type;
    logic [7:0]      header_flags;
    logic [31:0]     message_id;
    logic [7:0]      hops_left;
    logic [7:0]      hops_taken;
    logic [ID_W-1:0] source_id;
    logic [ID_W-1:0] dest_id;
    logic [4:0]      header_bytes;
    logic [8:0]      payload_bytes;
  } out_item_t;

  typedef struct packed {
    logic [7:0]           magic_byte;
    logic [7:0]           protocol_version;
    logic [47:0]          type_codes;
    logic [7:0]           addressed_mask;
    logic [7:0]           hop_max;
    logic [CFG_LEN_W-1:0] beacon_len;
    logic [CFG_LEN_W-1:0] msg_overhead;
    logic [CFG_LEN_W-1:0] plaintext_max;
  } cfg_t;

  typedef struct packed {
    logic [HDR_ADDR-1:0][7:0] hdr;
    logic [LEN_W-1:0]         len;
  } frame_rec_t;

endpackage

FILE: rtl/mesh_frame_header_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_frame_header_validator
// Byte-wide mesh frame header checker: intake, record queue, verdict stage
// and configuration registers.
// ----------------------------------------------------------------------------
// path: the last byte's record enters the queue, then the verdict enters the output register
// throughput: one byte per cycle while the queue has room, up to one verdict item per cycle
// rate set by the intake counter and a combinational check stage into the output register
// reset: config to defaults, byte counter zero, queue and output empty
// header bytes are not cleared; no start-up pass, items taken from reset
module mesh_frame_header_validator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  mfhv_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output mfhv_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [mfhv_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mfhv_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import mfhv_pkg::*;

  cfg_t       cfg_q, cfg_d;
  frame_rec_t push_rec, head_rec;
  logic       push, not_full, not_empty, pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAGIC:     cfg_d.magic_byte       = cfg_data_i[7:0];
        CFG_VERSION:   cfg_d.protocol_version = cfg_data_i[7:0];
        CFG_TYPES:     cfg_d.type_codes       = cfg_data_i[47:0];
        CFG_ADDR_MASK: cfg_d.addressed_mask   = cfg_data_i[7:0];
        CFG_HOP_MAX:   cfg_d.hop_max          = cfg_data_i[7:0];
        CFG_BEACON:    cfg_d.beacon_len       = cfg_data_i[CFG_LEN_W-1:0];
        CFG_OVERHEAD:  cfg_d.msg_overhead     = cfg_data_i[CFG_LEN_W-1:0];
        CFG_PT_MAX:    cfg_d.plaintext_max    = cfg_data_i[CFG_LEN_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_byte       <= 8'h00;
      cfg_q.protocol_version <= 8'h01;
      cfg_q.type_codes       <= 48'h0504_0302_0100;
      cfg_q.addressed_mask   <= 8'h01;
      cfg_q.hop_max          <= 8'd15;
      cfg_q.beacon_len       <= 9'd167;
      cfg_q.msg_overhead     <= 9'd28;
      cfg_q.plaintext_max    <= 9'd200;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mfhv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .rec_valid_o (push),
    .rec_ready_i (not_full),
    .rec_o       (push_rec)
  );

  mfhv_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_rec),
    .not_full_o  (not_full),
    .pop_i       (pop),
    .not_empty_o (not_empty),
    .head_o      (head_rec)
  );

  mfhv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rec_valid_i (not_empty),
    .rec_pop_o   (pop),
    .rec_i       (head_rec),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: rtl/mfhv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfhv_front
// Byte intake: counts frame length, captures header bytes and hands one
// frame record to the queue at the last byte.
// ----------------------------------------------------------------------------
module mfhv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mfhv_pkg::in_item_t  in_item_i,
  output logic                rec_valid_o,
  input  logic                rec_ready_i,
  output mfhv_pkg::frame_rec_t rec_o
);
  import mfhv_pkg::*;

  logic [LEN_W-1:0]         cnt_q, cnt_d, cnt_inc;
  logic [HDR_ADDR-1:0][7:0] hdr_q;
  logic                     acc;

  assign in_ready_o  = rec_ready_i;
  assign acc         = in_valid_i && in_ready_o;
  assign rec_valid_o = acc && in_item_i.last_byte;
  assign cnt_inc     = (cnt_q < LEN_W'(LEN_MAX)) ? cnt_q + LEN_W'(1) : cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (acc) begin
      cnt_d = in_item_i.last_byte ? '0 : cnt_inc;
    end
  end

  // current byte merged in so the record sees it at once
  always_comb begin
    for (int i = 0; i < HDR_ADDR; i++) begin
      rec_o.hdr[i] = (cnt_q == LEN_W'(i)) ? in_item_i.data_byte : hdr_q[i];
    end
    rec_o.len = cnt_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && (cnt_q < LEN_W'(HDR_ADDR))) begin
      hdr_q[cnt_q[HDR_IDX_W-1:0]] <= in_item_i.data_byte;
    end
  end

`ifndef SYNTHESIS
  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LEN_W'(LEN_MAX))
    else $error("byte counter beyond saturation");
  a_cnt_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_o |=> cnt_q == '0)
    else $error("counter not cleared after last byte");
`endif

endmodule

FILE: rtl/mfhv_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfhv_queue
// Short record queue between intake and verdict stages.
// ----------------------------------------------------------------------------
module mfhv_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mfhv_pkg::frame_rec_t push_data_i,
  output logic                 not_full_o,
  input  logic                 pop_i,
  output logic                 not_empty_o,
  output mfhv_pkg::frame_rec_t head_o
);
  import mfhv_pkg::*;

  frame_rec_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]       cnt_q, cnt_d;
  logic                    do_push, do_pop;

  assign not_full_o  = cnt_q != QCNT_W'(QDEPTH);
  assign not_empty_o = cnt_q != '0;
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign head_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue fill count out of range");
`endif

endmodule

FILE: rtl/mfhv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfhv_back
// Verdict stage: runs the ordered frame checks on one record and holds the
// result item in an output register.
// ----------------------------------------------------------------------------
module mfhv_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mfhv_pkg::cfg_t       cfg_i,
  input  logic                 rec_valid_i,
  output logic                 rec_pop_o,
  input  mfhv_pkg::frame_rec_t rec_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mfhv_pkg::out_item_t  out_item_o
);
  import mfhv_pkg::*;

  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, res;
  logic [7:0]           ptype;
  logic [5:0]           hit;
  logic                 known, addressed;
  logic [LEN_W-1:0]     hlen, n;
  logic [CMP_W-1:0]     n_x, lo_x, hi_x, bl_x;
  logic [63:0]          src64, dst64;
  status_e              st, rule_st;

  assign ptype = rec_i.hdr[2];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      hit[k] = ptype == cfg_i.type_codes[8*k +: 8];
    end
  end

  assign known     = |hit;
  assign addressed = |(rec_i.hdr[3] & cfg_i.addressed_mask);
  assign hlen      = addressed ? LEN_W'(HDR_ADDR) : LEN_W'(HDR_PLAIN);
  assign n         = rec_i.len - hlen;
  assign n_x       = CMP_W'(n);
  assign lo_x      = CMP_W'(cfg_i.msg_overhead);
  assign hi_x      = CMP_W'(cfg_i.msg_overhead) + CMP_W'(cfg_i.plaintext_max);
  assign bl_x      = CMP_W'(cfg_i.beacon_len);

  // beacon, ack, message, then the rest
  always_comb begin
    if (hit[0]) begin
      rule_st = (n_x == bl_x) ? ST_OK : ST_LENGTH;
    end else if (hit[5]) begin
      rule_st = (n_x == CMP_W'(ACK_PAYLOAD)) ? ST_OK : ST_LENGTH;
    end else if (hit[4]) begin
      rule_st = ((n_x > lo_x) && (n_x <= hi_x)) ? ST_OK : ST_LENGTH;
    end else begin
      rule_st = (n_x != '0) ? ST_OK : ST_LENGTH;
    end
  end

  always_comb begin
    if (rec_i.len > LEN_W'(MAX_FRAME)) begin
      st = ST_LENGTH;
    end else if (rec_i.len < LEN_W'(HDR_PLAIN)) begin
      st = ST_SHORT;
    end else if (rec_i.hdr[0] != cfg_i.magic_byte) begin
      st = ST_MAGIC;
    end else if (rec_i.hdr[1] != cfg_i.protocol_version) begin
      st = ST_VERSION;
    end else if (!known) begin
      st = ST_TYPE;
    end else if (addressed != !hit[0]) begin
      st = ST_FLAGS;
    end else if (addressed && (rec_i.len < LEN_W'(HDR_ADDR))) begin
      st = ST_SHORT;
    end else if ((rec_i.hdr[8] > cfg_i.hop_max) || (rec_i.hdr[9] > cfg_i.hop_max)) begin
      st = ST_HOPS;
    end else begin
      st = rule_st;
    end
  end

  always_comb begin
    src64 = '0;
    dst64 = '0;
    for (int i = 0; i < ID_BYTES; i++) begin
      src64[8*i +: 8] = rec_i.hdr[10 + i];
      dst64[8*i +: 8] = rec_i.hdr[HDR_PLAIN + i];
    end
  end

  always_comb begin
    res        = '0;
    res.status = st;
    if (st == ST_OK) begin
      res.packet_type   = ptype;
      res.header_flags  = rec_i.hdr[3];
      res.message_id    = {rec_i.hdr[7], rec_i.hdr[6], rec_i.hdr[5], rec_i.hdr[4]};
      res.hops_left     = rec_i.hdr[8];
      res.hops_taken    = rec_i.hdr[9];
      res.source_id     = src64[ID_W-1:0];
      res.dest_id       = addressed ? dst64[ID_W-1:0] : '0;
      res.header_bytes  = 5'(hlen);
      res.payload_bytes = 9'(n);
    end
  end

  assign rec_pop_o = rec_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (rec_pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status != ST_OK)) |->
      ((out_item_o.packet_type == '0) && (out_item_o.source_id == '0) &&
       (out_item_o.header_bytes == '0) && (out_item_o.payload_bytes == '0)))
    else $error("error verdict carries header fields");
  a_hdr_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status == ST_OK)) |->
      ((out_item_o.header_bytes == 5'(HDR_PLAIN)) ||
       (out_item_o.header_bytes == 5'(HDR_ADDR))))
    else $error("bad header length on good frame");
  a_plain_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status == ST_OK) &&
     (out_item_o.header_bytes == 5'(HDR_PLAIN))) |-> (out_item_o.dest_id == '0))
    else $error("destination id on plain frame");
`endif

endmodule
